>>> design/sha256e_pkg.sv
`timescale 1ns / 1ps
package sha256e_pkg;

    // Bytes in one message block.
    localparam int BLOCK_BYTES = 64;
    // Width of one word and number of words in the schedule memory.
    localparam int WORD_W      = 32;
    localparam int SCHED_WORDS = BLOCK_BYTES / 4;

    // One input transfer.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       is_last;
    } t_in_item;

    // One digest word transfer.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Eight 32-bit words: a..h or the chaining state, index 0 first.
    typedef logic [7:0][WORD_W-1:0] t_wvars;

endpackage

>>> design/sha256e_ram.sv
`timescale 1ns / 1ps
module sha256e_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

>>> design/sha256e_round.sv
`timescale 1ns / 1ps
module sha256e_round
    import sha256e_pkg::*;
(
    input  t_wvars      i_vars,
    input  logic [5:0]  i_round,
    input  logic [31:0] i_w,
    input  logic [31:0] i_x2,
    input  logic [31:0] i_x7,
    input  logic [31:0] i_x15,
    input  logic [31:0] i_x16,
    output t_wvars      o_vars,
    output logic [31:0] o_wnext
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    logic [31:0] s_sig0, s_sig1, s_bsig0, s_bsig1, s_ch, s_maj, s_t1, s_t2;

    // Message schedule expansion for rounds sixteen onwards.
    assign s_sig0  = rotr(i_x15, 7) ^ rotr(i_x15, 18) ^ (i_x15 >> 3);
    assign s_sig1  = rotr(i_x2, 17) ^ rotr(i_x2, 19) ^ (i_x2 >> 10);
    assign o_wnext = s_sig1 + i_x7 + s_sig0 + i_x16;

    // One compression round on a..h.
    assign s_bsig1 = rotr(i_vars[4], 6) ^ rotr(i_vars[4], 11) ^ rotr(i_vars[4], 25);
    assign s_bsig0 = rotr(i_vars[0], 2) ^ rotr(i_vars[0], 13) ^ rotr(i_vars[0], 22);
    assign s_ch    = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
    assign s_maj   = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2])
                   ^ (i_vars[1] & i_vars[2]);
    assign s_t1    = i_vars[7] + s_bsig1 + s_ch + round_k(i_round) + i_w;
    assign s_t2    = s_bsig0 + s_maj;

    always_comb begin
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + s_t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = s_t1 + s_t2;
    end

endmodule

>>> design/sha256_hash_engine_unit.sv
`timescale 1ns / 1ps
// SHA-256 engine taking at most one message byte per transfer and returning the eight digest
// words, most significant first, as eight output transfers after the transfer marked is_last.
// A byte is taken only while the engine is idle. Each complete 64-byte block then holds the
// input off while it is compressed: S_INIT loads a..h, each of the 64 rounds reads the schedule
// words it needs, rounds 16 to 63 also write a new schedule word, and S_ADD adds a..h into the
// chaining state. The round time is set by the 16-word schedule memory, which has two read
// ports and one write port: a schedule update reads four words and writes one. Ending a message
// costs a set-up state, the writing of up to sixteen padding words and one or two such block
// compressions, after which the digest words leave through an output register that need not be
// empty for the next message to start.
module sha256_hash_engine_unit
    import sha256e_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_ROUND  = 3'd2;
    localparam logic [2:0] S_ADD    = 3'd3;
    localparam logic [2:0] S_PADSET = 3'd4;
    localparam logic [2:0] S_PAD    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam logic [1:0] PH_RD0 = 2'd0;
    localparam logic [1:0] PH_RD1 = 2'd1;
    localparam logic [1:0] PH_SCH = 2'd2;
    localparam logic [1:0] PH_RND = 2'd3;

    localparam t_wvars IV = '{
        0: 32'h6a09e667, 1: 32'hbb67ae85, 2: 32'h3c6ef372, 3: 32'ha54ff53a,
        4: 32'h510e527f, 5: 32'h9b05688c, 6: 32'h1f83d9ab, 7: 32'h5be0cd19
    };

    localparam int AW = $clog2(SCHED_WORDS);

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_phase, n_phase;
    logic [5:0]        r_t, n_t;
    logic [5:0]        r_fill, n_fill;
    logic [63:0]       r_len, n_len;
    logic [23:0]       r_acc, n_acc;
    t_wvars            r_ch, n_ch;
    t_wvars            r_wv, n_wv;
    logic [31:0]       r_w, n_w;
    logic [31:0]       r_x2, n_x2;
    logic [31:0]       r_x15, n_x15;
    logic              r_fin, n_fin;
    logic              r_padded, n_padded;
    logic              r_ext, n_ext;
    logic              r_padw, n_padw;
    logic [AW-1:0]     r_pw, n_pw;
    logic [2:0]        r_oidx, n_oidx;
    t_out_item         r_out, n_out;
    logic              r_ovalid, n_ovalid;

    logic              s_in_fire;
    logic              s_load_out;
    logic              s_we;
    logic [AW-1:0]     s_waddr, s_ra0, s_ra1;
    logic [WORD_W-1:0] s_wdata, s_rd0, s_rd1, s_wnext, s_padword, s_padval;
    t_wvars            s_round_vars;

    assign s_in_fire   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign s_load_out  = !r_ovalid || i_out_ready;

    // Schedule memory: block words and the rolling message schedule.
    sha256e_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SCHED_WORDS)
    ) u_sched (
        .i_clk    (i_clk),
        .i_we     (s_we),
        .i_waddr  (s_waddr),
        .i_wdata  (s_wdata),
        .i_raddr0 (s_ra0),
        .i_raddr1 (s_ra1),
        .o_rdata0 (s_rd0),
        .o_rdata1 (s_rd1)
    );

    // Round and schedule datapath.
    sha256e_round u_round (
        .i_vars  (r_wv),
        .i_round (r_t),
        .i_w     (r_w),
        .i_x2    (r_x2),
        .i_x7    (s_rd0),
        .i_x15   (r_x15),
        .i_x16   (s_rd1),
        .o_vars  (s_round_vars),
        .o_wnext (s_wnext)
    );

    // Word holding the held tail bytes followed by the 0x80 marker byte.
    always_comb begin
        case (r_fill[1:0])
            2'd0:    s_padword = 32'h8000_0000;
            2'd1:    s_padword = {r_acc[7:0], 8'h80, 16'h0000};
            2'd2:    s_padword = {r_acc[15:0], 8'h80, 8'h00};
            default: s_padword = {r_acc[23:0], 8'h80};
        endcase
    end

    // Padding word for the current write position.
    always_comb begin
        if (r_padw) begin
            s_padval = s_padword;
        end else if (!r_ext && r_pw == AW'(SCHED_WORDS - 2)) begin
            s_padval = r_len[63:32];
        end else if (!r_ext && r_pw == AW'(SCHED_WORDS - 1)) begin
            s_padval = r_len[31:0];
        end else begin
            s_padval = '0;
        end
    end

    // Sequencer: byte packing, padding, rounds, chaining and digest output.
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_t      = r_t;
        n_fill   = r_fill;
        n_len    = r_len;
        n_acc    = r_acc;
        n_ch     = r_ch;
        n_wv     = r_wv;
        n_w      = r_w;
        n_x2     = r_x2;
        n_x15    = r_x15;
        n_fin    = r_fin;
        n_padded = r_padded;
        n_ext    = r_ext;
        n_padw   = r_padw;
        n_pw     = r_pw;
        n_oidx   = r_oidx;
        n_out    = r_out;
        n_ovalid = r_ovalid;
        s_we     = 1'b0;
        s_waddr  = r_t[AW-1:0];
        s_wdata  = s_wnext;
        s_ra0    = r_t[AW-1:0];
        s_ra1    = r_t[AW-1:0];

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_in_fire) begin
                    if (i_in_data.byte_present) begin
                        n_acc  = {r_acc[15:0], i_in_data.msg_byte};
                        n_fill = r_fill + 6'd1;
                        n_len  = r_len + 64'd8;
                        // A word is complete on its fourth byte.
                        if (r_fill[1:0] == 2'd3) begin
                            s_we    = 1'b1;
                            s_waddr = r_fill[5:2];
                            s_wdata = {r_acc, i_in_data.msg_byte};
                        end
                    end
                    if (i_in_data.byte_present && r_fill == 6'(BLOCK_BYTES - 1)) begin
                        n_state  = S_INIT;
                        n_fin    = i_in_data.is_last;
                        n_padded = 1'b0;
                    end else if (i_in_data.is_last) begin
                        n_state = S_PADSET;
                        n_fin   = 1'b1;
                    end
                end
            end
            S_PADSET: begin
                n_pw     = r_fill[5:2];
                n_padw   = 1'b1;
                n_ext    = (r_fill >= 6'(BLOCK_BYTES - 8));
                n_padded = 1'b1;
                n_state  = S_PAD;
            end
            S_PAD: begin
                s_we    = 1'b1;
                s_waddr = r_pw;
                s_wdata = s_padval;
                n_padw  = 1'b0;
                n_pw    = r_pw + 1'b1;
                if (r_pw == AW'(SCHED_WORDS - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_wv    = r_ch;
                n_t     = '0;
                n_phase = PH_RD0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                case (r_phase)
                    PH_RD0: begin
                        s_ra0   = (r_t[5:4] == 2'd0) ? r_t[AW-1:0] : r_t[AW-1:0] - AW'(2);
                        s_ra1   = r_t[AW-1:0] - AW'(15);
                        n_phase = PH_RD1;
                    end
                    PH_RD1: begin
                        if (r_t[5:4] == 2'd0) begin
                            n_w     = s_rd0;
                            n_phase = PH_RND;
                        end else begin
                            n_x2    = s_rd0;
                            n_x15   = s_rd1;
                            s_ra0   = r_t[AW-1:0] - AW'(7);
                            s_ra1   = r_t[AW-1:0];
                            n_phase = PH_SCH;
                        end
                    end
                    PH_SCH: begin
                        s_we    = 1'b1;
                        s_waddr = r_t[AW-1:0];
                        s_wdata = s_wnext;
                        n_w     = s_wnext;
                        n_phase = PH_RND;
                    end
                    default: begin
                        n_wv    = s_round_vars;
                        n_t     = r_t + 6'd1;
                        n_phase = PH_RD0;
                        if (r_t == 6'd63) begin
                            n_state = S_ADD;
                        end
                    end
                endcase
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_ch[i] = r_ch[i] + r_wv[i];
                end
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (!r_padded) begin
                    n_state = S_PADSET;
                end else if (r_ext) begin
                    // Extra block of zeros and the length.
                    n_ext   = 1'b0;
                    n_pw    = '0;
                    n_padw  = 1'b0;
                    n_state = S_PAD;
                end else begin
                    n_oidx  = '0;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (s_load_out) begin
                    n_out.digest_word = r_ch[r_oidx];
                    n_out.word_index  = r_oidx;
                    n_out.last_word   = (r_oidx == 3'd7);
                    n_ovalid          = 1'b1;
                    n_oidx            = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) begin
                        n_ch    = IV;
                        n_len   = '0;
                        n_fill  = '0;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and chaining state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_RD0;
            r_t      <= '0;
            r_fill   <= '0;
            r_len    <= '0;
            r_ch     <= IV;
            r_fin    <= 1'b0;
            r_padded <= 1'b0;
            r_ext    <= 1'b0;
            r_padw   <= 1'b0;
            r_pw     <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_t      <= n_t;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_ch     <= n_ch;
            r_fin    <= n_fin;
            r_padded <= n_padded;
            r_ext    <= n_ext;
            r_padw   <= n_padw;
            r_pw     <= n_pw;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_wv  <= n_wv;
        r_w   <= n_w;
        r_x2  <= n_x2;
        r_x15 <= n_x15;
        r_out <= n_out;
    end

endmodule

>>> design/sha256e_checker.sv
`timescale 1ns / 1ps
module sha256e_checker
    import sha256e_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic s_in_xfer;
    assign s_in_xfer = i_in_valid && o_in_ready;

    // No digest word is offered straight after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("digest word offered after reset");

    // A stalled digest word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled digest word changed");

    // The final word flag marks word seven and no other.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_word == (o_out_data.word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // The end of a message stops input while the digest is worked out.
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_xfer && i_in_data.is_last |=> !o_in_ready)
        else $error("input taken right after end of message");

    // An empty transfer leaves the engine ready.
    a_idle_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in_xfer && !i_in_data.is_last && !i_in_data.byte_present |=> o_in_ready)
        else $error("empty transfer made the engine busy");

endmodule

bind sha256_hash_engine_unit sha256e_checker u_sha256e_checker (.*);

>>> sim/sha256_hash_engine_unit_tb.sv
`timescale 1ns / 1ps
module sha256_hash_engine_unit_tb;
    import sha256e_pkg::*;

    // SHA-256 round constants and initial hash values, index 0 first.
    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [0:7][31:0] HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Start of the length field within the final block.
    localparam int unsigned LEN_POS = BLOCK_BYTES - 8;

    // Idling per phase, in percent, and the message length that opens each phase.
    localparam logic [0:3][7:0] SEND_IDLE_PCT  = {8'd0, 8'd63, 8'd0, 8'd27};
    localparam logic [0:3][7:0] RECV_STALL_PCT = {8'd0, 8'd0, 8'd63, 8'd27};
    localparam logic [0:3][7:0] PHASE_TAIL_LEN = {8'd55, 8'd56, 8'd63, 8'd64};
    localparam int unsigned ITEMS_PER_PHASE = 115;
    localparam int unsigned DRAIN_CYCLES    = 600;

    // Predicts the digest of each message and checks the digest words against it.
    class digest_scoreboard;
        logic [31:0] chain [8];
        logic [7:0]  blk_bytes [64];
        int unsigned fill;
        logic [63:0] msg_bits;
        t_out_item   digest_queue [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            int unsigned i;
            for (i = 0; i < 8; i++) begin
                chain[i] = HASH_INIT[i];
            end
            msg_bits = '0;
            fill     = 0;
        endfunction

        function logic [31:0] rotr(logic [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        // One SHA-256 compression of the current block into the chaining state.
        function void compress();
            logic [31:0] sched [64];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
            int unsigned t;
            for (t = 0; t < 16; t++) begin
                sched[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
            end
            for (t = 16; t < 64; t++) begin
                s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
                s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
                sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
            end
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (t = 0; t < 64; t++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                     + ROUND_K[t] + sched[t];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        // Takes one accepted input transfer; a closing transfer queues eight digest words.
        function void note_item(t_in_item item);
            t_out_item word;
            int unsigned i;
            if (item.byte_present) begin
                blk_bytes[fill] = item.msg_byte;
                fill++;
                msg_bits += 64'd8;
                if (fill == BLOCK_BYTES) begin
                    compress();
                    fill = 0;
                end
            end
            if (item.is_last) begin
                blk_bytes[fill] = 8'h80;
                for (i = fill + 1; i < BLOCK_BYTES; i++) begin
                    blk_bytes[i] = 8'h00;
                end
                // No room left for the length: close this block and pad a fresh one.
                if (fill >= LEN_POS) begin
                    compress();
                    for (i = 0; i < BLOCK_BYTES; i++) begin
                        blk_bytes[i] = 8'h00;
                    end
                end
                for (i = 0; i < 8; i++) begin
                    blk_bytes[LEN_POS + i] = 8'(msg_bits >> (56 - 8 * i));
                end
                compress();
                for (i = 0; i < 8; i++) begin
                    word.digest_word = chain[i];
                    word.word_index  = 3'(i);
                    word.last_word   = (i == 7);
                    digest_queue.push_back(word);
                end
                restart();
            end
        endfunction

        // Compares one accepted digest word with the oldest one predicted.
        function void check_word(t_out_item got);
            t_out_item want;
            if (digest_queue.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                         $time, got.digest_word, got.word_index, got.last_word);
                return;
            end
            want = digest_queue.pop_front();
            if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
                got.last_word !== want.last_word) begin
                mismatches++;
                $display("%0t: digest mismatch: expected %h idx %0d last %0b, actual %h idx %0d last %0b",
                         $time, want.digest_word, want.word_index, want.last_word,
                         got.digest_word, got.word_index, got.last_word);
            end
        endfunction

        function int unsigned pending();
            return digest_queue.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned items_sent = 0;
    digest_scoreboard sb;

    sha256_hash_engine_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #4 clk = ~clk;

    // Watch both channels for transfers and drive the receiver's stalls.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_item(in_data);
            end
            if (out_valid && out_ready) begin
                sb.check_word(out_data);
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_in_item make_item(logic [7:0] b, logic present, logic last);
        t_in_item item;
        item.msg_byte     = b;
        item.byte_present = present;
        item.is_last      = last;
        return item;
    endfunction

    // Presents one item, after an optional idle gap, and waits for its transfer.
    task automatic send_item(input t_in_item item);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        if (item.byte_present || item.is_last) begin
            items_sent++;
        end
    endtask

    // A message of random bytes with occasional idle items, ended either on its
    // last byte or by a separate closing item.
    task automatic send_message(input int unsigned nbytes);
        int unsigned n;
        logic end_on_byte;
        end_on_byte = (nbytes != 0) && ($urandom_range(1) == 1);
        for (n = 0; n < nbytes; n++) begin
            if ($urandom_range(9) == 0) begin
                send_item(make_item(8'($urandom), 1'b0, 1'b0));
            end
            send_item(make_item(8'($urandom), 1'b1, end_on_byte && (n == nbytes - 1)));
        end
        if (!end_on_byte) begin
            send_item(make_item(8'($urandom), 1'b0, 1'b1));
        end
    endtask

    // Mostly short messages, some near one block and a few spanning two or three.
    function automatic int unsigned pick_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) begin
            return $urandom_range(15);
        end else if (roll < 85) begin
            return $urandom_range(70, 50);
        end
        return $urandom_range(140, 71);
    endfunction

    initial begin
        int unsigned phase;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, single extreme bytes, a short text and a
        // message closed by an item without a byte after an idle item.
        send_item(make_item(8'h3c, 1'b0, 1'b1));
        send_item(make_item(8'hff, 1'b1, 1'b1));
        send_item(make_item(8'h00, 1'b1, 1'b1));
        send_item(make_item(8'h61, 1'b1, 1'b0));
        send_item(make_item(8'h62, 1'b1, 1'b0));
        send_item(make_item(8'h63, 1'b1, 1'b1));
        send_item(make_item(8'h00, 1'b1, 1'b0));
        send_item(make_item(8'hff, 1'b1, 1'b0));
        send_item(make_item(8'h5a, 1'b0, 1'b0));
        send_item(make_item(8'ha5, 1'b0, 1'b1));

        // Random messages in four idling phases, each opening with a message length
        // around the point where the length field no longer fits, or of a full block.
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = SEND_IDLE_PCT[phase];
            recv_stall_pct <= RECV_STALL_PCT[phase];
            send_message(PHASE_TAIL_LEN[phase]);
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
                send_message(pick_len());
            end
        end
        in_valid <= 1'b0;

        // Drain the digest words, then watch for stray ones.
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("sha256_hash_engine_unit regression: pass");
        end else begin
            $display("sha256_hash_engine_unit regression: fail");
        end
        $finish;
    end

    // Watchdog in case the engine hangs.
    initial begin
        #20000000;
        $display("sha256_hash_engine_unit regression: fail");
        $finish;
    end

endmodule

>>> files.f
design/sha256e_pkg.sv
design/sha256e_ram.sv
design/sha256e_round.sv
design/sha256_hash_engine_unit.sv
design/sha256e_checker.sv
sim/sha256_hash_engine_unit_tb.sv
